>>> hdl/oakv_pkg.sv
package oakv_pkg;

  localparam logic [63:0] HASH_SEED = 64'h1337_1337_dead_beef;

  localparam logic [1:0] ACT_PUT  = 2'd0;
  localparam logic [1:0] ACT_GET  = 2'd1;
  localparam logic [1:0] ACT_DEL  = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  localparam logic [1:0] RS_OK   = 2'd0;
  localparam logic [1:0] RS_MISS = 2'd1;
  localparam logic [1:0] RS_FULL = 2'd2;

  localparam int CFG_W = 11;
  localparam int MOD_STEPS = 64;

endpackage

>>> hdl/open_addressing_kv_table.sv
// Sequence: the key is hashed one byte at a time, a bit-serial modulo maps
//   the hash to a start slot, each slot probed is read and then checked, and
//   the result word is loaded. Throughput: one request at a time; a new
//   request is taken only while the table is idle.
// Reset: synchronous; a clearing pass marks every slot empty before the first
//   request is taken. table_size resets to TABLE_DEPTH.
module open_addressing_kv_table #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BYTES   = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [oakv_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                action,
  input  logic [63:0]               key_bytes,
  input  logic [63:0]               value_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status,
  output logic [63:0]               value_out,
  output logic [oakv_pkg::CFG_W-1:0] entry_count
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SZ_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CW    = (SZ_W > oakv_pkg::CFG_W) ? SZ_W : oakv_pkg::CFG_W;
  localparam int MC_W  = $clog2(oakv_pkg::MOD_STEPS);
  localparam int CNT_W = oakv_pkg::CFG_W;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_HASH, S_MOD, S_RD, S_CHK, S_RESP
  } state_t;

  state_t state;

  logic [CW-1:0]    table_size;
  logic [SZ_W-1:0]  eff_size;
  logic [SZ_W-1:0]  size_q;
  logic [SZ_W-1:0]  left;
  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic [IDX_W-1:0] tomb_idx;
  logic             tomb_seen;
  logic [1:0]       act_q;
  logic [63:0]      key_q;
  logic [63:0]      kb;
  logic [63:0]      val_q;
  logic [63:0]      h;
  logic [SZ_W-1:0]  rem;
  logic [SZ_W:0]    rem_sh;
  logic [SZ_W:0]    rem_diff;
  logic [SZ_W-1:0]  rem_new;
  logic [MC_W-1:0]  mcnt;
  logic [1:0]       res_status;
  logic [63:0]      res_value;
  logic [oakv_pkg::CFG_W-1:0] live_count;
  logic [63:0]      key_n;
  logic [7:0]       cbyte;

  logic [1:0]  state_mem [TABLE_DEPTH];
  logic [63:0] key_mem   [TABLE_DEPTH];
  logic [63:0] val_mem   [TABLE_DEPTH];
  logic [1:0]  rd_state;
  logic [63:0] rd_key;
  logic [63:0] rd_val;

  // write port controls
  logic             st_we;
  logic             kv_we;
  logic [IDX_W-1:0] wr_idx;
  logic [1:0]       wr_state;

  // probe decisions
  logic             is_put;
  logic             key_hit;
  logic             tomb_hit;
  logic [IDX_W-1:0] tomb_at;
  logic             last_probe;

  // keep bytes up to the first zero byte and within KEY_BYTES
  always_comb begin
    logic run;
    run = 1'b1;
    key_n = '0;
    for (int b = 0; b < 8; b++) begin
      if (b >= KEY_BYTES || key_bytes[56-8*b +: 8] == 8'd0) begin
        run = 1'b0;
      end
      if (run) begin
        key_n[56-8*b +: 8] = key_bytes[56-8*b +: 8];
      end
    end
  end

  always_comb begin
    if (table_size < CW'(2)) begin
      eff_size = SZ_W'(2);
    end else if (table_size > CW'(TABLE_DEPTH)) begin
      eff_size = SZ_W'(TABLE_DEPTH);
    end else begin
      eff_size = table_size[SZ_W-1:0];
    end
  end

  assign cbyte    = kb[63:56];
  assign rem_sh   = {rem, h[63]};
  assign rem_diff = rem_sh - {1'b0, size_q};
  assign rem_new  = rem_diff[SZ_W] ? rem_sh[SZ_W-1:0] : rem_diff[SZ_W-1:0];
  assign idx_next = (SZ_W'(idx) + SZ_W'(1) == size_q) ? '0 : idx + IDX_W'(1);

  assign is_put     = (act_q == oakv_pkg::ACT_PUT);
  assign key_hit    = (rd_key == key_q);
  assign tomb_hit   = tomb_seen || (is_put && rd_state == oakv_pkg::SLOT_TOMB);
  assign tomb_at    = tomb_seen ? tomb_idx : idx;
  assign last_probe = (left == SZ_W'(1));

  always_comb begin
    st_we    = 1'b0;
    kv_we    = 1'b0;
    wr_idx   = idx;
    wr_state = oakv_pkg::SLOT_LIVE;
    if (state == S_CLR) begin
      st_we    = 1'b1;
      wr_idx   = clr_idx;
      wr_state = oakv_pkg::SLOT_EMPTY;
    end else if (state == S_CHK) begin
      case (rd_state)
        oakv_pkg::SLOT_EMPTY: begin
          if (is_put) begin
            st_we  = 1'b1;
            kv_we  = 1'b1;
            wr_idx = tomb_at;
          end
        end
        oakv_pkg::SLOT_TOMB: begin
          if (last_probe && is_put) begin
            st_we  = 1'b1;
            kv_we  = 1'b1;
            wr_idx = tomb_at;
          end
        end
        default: begin
          if (key_hit) begin
            if (is_put) begin
              kv_we = 1'b1;
            end else if (act_q == oakv_pkg::ACT_DEL) begin
              st_we    = 1'b1;
              wr_state = oakv_pkg::SLOT_TOMB;
            end
          end else if (last_probe && is_put && tomb_seen) begin
            st_we  = 1'b1;
            kv_we  = 1'b1;
            wr_idx = tomb_idx;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      state_mem[wr_idx] <= wr_state;
    end
    rd_state <= state_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (kv_we) begin
      key_mem[wr_idx] <= key_q;
      val_mem[wr_idx] <= val_q;
    end
    rd_key <= key_mem[idx];
    rd_val <= val_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_idx    <= '0;
      table_size <= CW'(TABLE_DEPTH);
      live_count <= '0;
      out_valid  <= 1'b0;
      tomb_seen  <= 1'b0;
    end else begin
      if (cfg_we) begin
        table_size <= CW'(cfg_wdata);
      end
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == IDX_W'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            act_q      <= action;
            key_q      <= key_n;
            kb         <= key_n;
            val_q      <= value_in;
            h          <= oakv_pkg::HASH_SEED;
            size_q     <= eff_size;
            rem        <= '0;
            mcnt       <= '0;
            tomb_seen  <= 1'b0;
            res_status <= oakv_pkg::RS_MISS;
            res_value  <= '0;
            state      <= (action == oakv_pkg::ACT_NONE) ? S_RESP : S_HASH;
          end
        end
        S_HASH: begin
          if (cbyte == 8'd0) begin
            state <= S_MOD;
          end else begin
            h  <= ((h ^ {56'd0, cbyte}) << 8) + {56'd0, cbyte};
            kb <= kb << 8;
          end
        end
        S_MOD: begin
          rem  <= rem_new;
          h    <= h << 1;
          mcnt <= mcnt + MC_W'(1);
          if (mcnt == MC_W'(oakv_pkg::MOD_STEPS - 1)) begin
            idx   <= rem_new[IDX_W-1:0];
            left  <= size_q - SZ_W'(1);
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          case (rd_state)
            oakv_pkg::SLOT_EMPTY: begin
              if (is_put) begin
                live_count <= live_count + CNT_W'(1);
                res_status <= oakv_pkg::RS_OK;
              end
              state <= S_RESP;
            end
            default: begin
              if (rd_state != oakv_pkg::SLOT_TOMB && key_hit) begin
                if (act_q == oakv_pkg::ACT_GET) begin
                  res_value <= rd_val;
                end else if (act_q == oakv_pkg::ACT_DEL) begin
                  live_count <= live_count - CNT_W'(1);
                end
                res_status <= oakv_pkg::RS_OK;
                state      <= S_RESP;
              end else begin
                if (rd_state == oakv_pkg::SLOT_TOMB && is_put && !tomb_seen) begin
                  tomb_seen <= 1'b1;
                  tomb_idx  <= idx;
                end
                if (last_probe) begin
                  // probe ran out: a put falls back to the first tombstone
                  if (is_put) begin
                    if (tomb_hit) begin
                      live_count <= live_count + CNT_W'(1);
                      res_status <= oakv_pkg::RS_OK;
                    end else begin
                      res_status <= oakv_pkg::RS_FULL;
                    end
                  end
                  state <= S_RESP;
                end else begin
                  idx   <= idx_next;
                  left  <= left - SZ_W'(1);
                  state <= S_RD;
                end
              end
            end
          endcase
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            value_out   <= res_value;
            entry_count <= live_count;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> !in_ready)
    else $error("ready during clearing pass");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == oakv_pkg::RS_OK || status == oakv_pkg::RS_MISS ||
                   status == oakv_pkg::RS_FULL))
    else $error("bad status code");

  a_miss_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != oakv_pkg::RS_OK |-> value_out == 64'd0)
    else $error("value on a miss");
`endif

endmodule
